// ----- design/mpe_pkg.sv -----
// Package for the modular exponentiation block: modulus constants,
// Barrett reciprocal and the request/response words of the mulmod unit.
// No dependencies.
package mpe_pkg;

  localparam int unsigned ResW = 30;
  localparam int unsigned ExpBitsDefault = 32;

  // Modulus 1000000007 and its double (the double fits in 32 bits)
  localparam logic [ResW-1:0] PrimeMod = 30'd1000000007;
  localparam logic [31:0] TwoPrime = 32'd2000000014;

  // Barrett reciprocal floor(2^60 / p), 31 bits
  localparam logic [63:0] BarrettFull = (64'd1 << 60) / 64'd1000000007;
  localparam logic [30:0] BarrettM = BarrettFull[30:0];

  // Request word to the shared mulmod unit
  typedef struct packed {
    logic            start;
    logic [ResW-1:0] op_a;
    logic [ResW-1:0] op_b;
  } mpe_req_t;

  // Response word from the mulmod unit
  typedef struct packed {
    logic            done;
    logic [ResW-1:0] result;
  } mpe_rsp_t;

endpackage

// ----- design/mpe_mulmod.sv -----
// Shared modular multiplier: (a * b) mod p by Barrett reduction, using one
// 32x32 multiplier three times in sequence. Depends on mpe_pkg.
module mpe_mulmod (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  mpe_pkg::mpe_req_t req_i,
  output mpe_pkg::mpe_rsp_t rsp_o
);

  typedef enum logic [1:0] {
    M_IDLE,
    M_QUO,
    M_REM,
    M_FIX
  } mstate_e;

  mstate_e                    state_q;
  logic [59:0]                prod_q;
  logic [mpe_pkg::ResW-1:0]   quo_q;
  logic [31:0]                rem_q;
  logic                       done_q;
  logic [mpe_pkg::ResW-1:0]   res_q;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_y;
  logic [31:0] rem_fix;

  // operand select for the one multiplier
  always_comb begin
    case (state_q)
      M_IDLE: begin
        mul_a = {2'b00, req_i.op_a};
        mul_b = {2'b00, req_i.op_b};
      end
      M_QUO: begin
        mul_a = prod_q[59:28];
        mul_b = {1'b0, mpe_pkg::BarrettM};
      end
      M_REM: begin
        mul_a = {2'b00, quo_q};
        mul_b = {2'b00, mpe_pkg::PrimeMod};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_y = 64'(mul_a) * 64'(mul_b);

  // remainder is below 3p: at most two corrections
  always_comb begin
    if (rem_q >= mpe_pkg::TwoPrime) begin
      rem_fix = rem_q - mpe_pkg::TwoPrime;
    end else if (rem_q >= {2'b00, mpe_pkg::PrimeMod}) begin
      rem_fix = rem_q - {2'b00, mpe_pkg::PrimeMod};
    end else begin
      rem_fix = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      prod_q  <= '0;
      quo_q   <= '0;
      rem_q   <= '0;
      done_q  <= 1'b0;
      res_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (req_i.start) begin
            prod_q  <= mul_y[59:0];
            state_q <= M_QUO;
          end
        end
        M_QUO: begin
          quo_q   <= mul_y[61:32];
          state_q <= M_REM;
        end
        M_REM: begin
          // true remainder < 2^32, so low words suffice
          rem_q   <= prod_q[31:0] - mul_y[31:0];
          state_q <= M_FIX;
        end
        M_FIX: begin
          res_q   <= rem_fix[mpe_pkg::ResW-1:0];
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: begin
          state_q <= M_IDLE;
        end
      endcase
    end
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

`ifndef SYNTHESIS
  a_done_after_fix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q) == M_FIX)
    else $error("mulmod done without correction step");

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> res_q < mpe_pkg::PrimeMod)
    else $error("mulmod result not reduced");

  a_start_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == M_IDLE)
    else $error("mulmod request while busy");
`endif

endmodule

// ----- design/mod_prime_exponentiation.sv -----
// Top level: base^exponent mod 1000000007 by MSB-first square-and-multiply.
// Depends on mpe_pkg and mpe_mulmod.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+----------------------------------
//  input    | base_i, exponent_i             | word taken when start && !busy
//  result   | residue_o                      | valid_o high one cycle, no stall
//
// Each exponent bit costs one squaring on the shared multiplier-reducer plus one
// multiply if the bit is set; the sequencer takes no new word until the residue
// of the current one is shown.
// busy stays high from the accepting edge until residue_o is shown; it drops
// in the cycle valid_o is high, so the next word can start then.
// Reset clears the sequencer; no state survives between words.
module mod_prime_exponentiation #(
  parameter int unsigned ExpBits = mpe_pkg::ExpBitsDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [mpe_pkg::ResW-1:0] base_i,
  input  logic [ExpBits-1:0]       exponent_i,
  output logic                     valid_o,
  output logic [mpe_pkg::ResW-1:0] residue_o
);

  localparam int unsigned CntW = (ExpBits > 1) ? $clog2(ExpBits) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_SQR_WAIT,
    S_MUL,
    S_MUL_WAIT
  } state_e;

  state_e                   state_q;
  logic [mpe_pkg::ResW-1:0] base_q;
  logic [mpe_pkg::ResW-1:0] acc_q;
  logic [ExpBits-1:0]       exp_q;
  logic [CntW-1:0]          cnt_q;
  logic                     valid_q;
  logic [mpe_pkg::ResW-1:0] residue_q;

  logic [mpe_pkg::ResW-1:0] base_red;
  logic                     last_bit;

  mpe_pkg::mpe_req_t req;
  mpe_pkg::mpe_rsp_t rsp;

  // one subtraction brings any 30-bit base below p
  assign base_red = (base_i >= mpe_pkg::PrimeMod) ? base_i - mpe_pkg::PrimeMod : base_i;
  assign last_bit = (cnt_q == '0);

  // square uses acc twice, multiply uses acc and base
  assign req.start = (state_q == S_SQR) || (state_q == S_MUL);
  assign req.op_a  = acc_q;
  assign req.op_b  = (state_q == S_MUL) ? base_q : acc_q;

  mpe_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      base_q    <= '0;
      acc_q     <= '0;
      exp_q     <= '0;
      cnt_q     <= '0;
      valid_q   <= 1'b0;
      residue_q <= '0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start) begin
            base_q  <= base_red;
            exp_q   <= exponent_i;
            acc_q   <= {{(mpe_pkg::ResW-1){1'b0}}, 1'b1};
            cnt_q   <= CntW'(ExpBits - 1);
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          state_q <= S_SQR_WAIT;
        end
        S_SQR_WAIT: begin
          if (rsp.done) begin
            acc_q <= rsp.result;
            if (exp_q[ExpBits-1]) begin
              state_q <= S_MUL;
            end else if (last_bit) begin
              residue_q <= rsp.result;
              valid_q   <= 1'b1;
              state_q   <= S_IDLE;
            end else begin
              exp_q   <= exp_q << 1;
              cnt_q   <= cnt_q - 1'b1;
              state_q <= S_SQR;
            end
          end
        end
        S_MUL: begin
          state_q <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (rsp.done) begin
            acc_q <= rsp.result;
            if (last_bit) begin
              residue_q <= rsp.result;
              valid_q   <= 1'b1;
              state_q   <= S_IDLE;
            end else begin
              exp_q   <= exp_q << 1;
              cnt_q   <= cnt_q - 1'b1;
              state_q <= S_SQR;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_q != S_IDLE);
  assign valid_o   = valid_q;
  assign residue_o = residue_q;

`ifndef SYNTHESIS
  a_valid_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o)
    else $error("result strobe longer than one cycle");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result shown while sequencer still running");

  a_residue_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> residue_o < mpe_pkg::PrimeMod)
    else $error("residue not below modulus");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !valid_o)
    else $error("accepted word did not start the sequencer");
`endif

endmodule

// ----- bench/tb.sv -----
// Testbench for mod_prime_exponentiation: directed and random base/exponent
// words checked against an in-bench square-and-multiply predictor.
// Depends on mpe_pkg and the mod_prime_exponentiation RTL.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned ResW    = mpe_pkg::ResW;
  localparam int unsigned ExpBits = mpe_pkg::ExpBitsDefault;
  // Longest item has every exponent bit set; this is well past it plus a sender gap.
  localparam int unsigned StallLimit = 4000;
  localparam int unsigned TailCycles = 20;
  localparam int unsigned RandomWords = 930;

  // Scoreboard: predicts the residue of each accepted word, matches results
  // in order.
  class ResidueScoreboard;
    logic [ResW-1:0] residue_q[$];
    int unsigned     errors = 0;

    task report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // MSB-first square-and-multiply; every product stays below 2^60.
    function logic [ResW-1:0] predict_residue(input logic [ResW-1:0] b,
                                              input logic [ExpBits-1:0] e);
      longint unsigned p;
      longint unsigned bb;
      longint unsigned acc;
      p   = longint'(mpe_pkg::PrimeMod);
      bb  = longint'(b);
      acc = 1;
      if (bb >= p) bb -= p;   // base above the modulus: one subtraction
      for (int i = ExpBits - 1; i >= 0; i--) begin
        acc = (acc * acc) % p;
        if (e[i]) acc = (acc * bb) % p;
      end
      return acc[ResW-1:0];
    endfunction

    function void note_word(input logic [ResW-1:0] b, input logic [ExpBits-1:0] e);
      residue_q = {residue_q, predict_residue(b, e)};
    endfunction

    task check_residue(input logic [ResW-1:0] got);
      logic [ResW-1:0] want;
      if (residue_q.size() == 0) begin
        report_mismatch($sformatf("residue %0d with no word outstanding", got));
      end else begin
        want = residue_q.pop_front();
        if (got !== want)
          report_mismatch($sformatf("residue got %0d want %0d", got, want));
      end
    endtask

    task check_drained();
      if (residue_q.size() != 0)
        report_mismatch($sformatf("%0d residues never arrived", residue_q.size()));
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [ResW-1:0]    base_i = '0;
  logic [ExpBits-1:0] exponent_i = '0;
  logic               valid_o;
  logic [ResW-1:0]    residue_o;

  ResidueScoreboard sb = new;
  bit               burst_mode = 1'b0;   // no sender gaps while set
  int unsigned      idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  mod_prime_exponentiation #(
    .ExpBits(ExpBits)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .base_i    (base_i),
    .exponent_i(exponent_i),
    .valid_o   (valid_o),
    .residue_o (residue_o)
  );

  // Result monitor. valid_o is a one-cycle strobe with no backpressure;
  // the value sampled here is the one held through the cycle that ends now.
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_residue(residue_o);
  end

  // Watchdog: any accepted word or result clears the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Drive one word. Sometimes first let the block go idle so the gap lands
  // after the result instead of inside the busy window. start is left high
  // after acceptance; the next call lowers it only if it idles.
  task automatic send_word(input logic [ResW-1:0] b, input logic [ExpBits-1:0] e);
    int unsigned gap;
    bit          hold;
    gap  = burst_mode ? 0 : $urandom_range(0, 5);
    hold = !burst_mode && ($urandom_range(0, 2) == 0);
    if (hold || gap != 0) begin
      start <= 1'b0;
      if (hold) begin
        do @(posedge clk_i); while (busy);
      end
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    base_i     <= b;
    exponent_i <= e;
    do @(posedge clk_i); while (busy);
    sb.note_word(b, e);
  endtask

  // Sender stands still until the block has shown its last residue.
  task automatic wait_block_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [ResW-1:0] pick_base();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 65) return ResW'($urandom_range(0, mpe_pkg::PrimeMod - 1));
    if (sel < 77) return ResW'($urandom_range(mpe_pkg::PrimeMod, (1 << ResW) - 1));
    if (sel < 87) return ResW'($urandom_range(0, 3));
    if (sel < 94) return mpe_pkg::PrimeMod - ResW'($urandom_range(1, 2));
    return ResW'($urandom);
  endfunction

  function automatic logic [ExpBits-1:0] pick_exponent();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return ExpBits'($urandom);
    if (sel < 75) return ExpBits'($urandom_range(0, 15));
    if (sel < 85) return ExpBits'(1) << $urandom_range(0, ExpBits - 1);
    if (sel < 93) return ~(ExpBits'(1) << $urandom_range(0, ExpBits - 1));
    return ExpBits'($urandom) >> $urandom_range(0, ExpBits - 1);
  endfunction

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero exponent (incl. zero base), field extremes, bases at
    // and above the modulus, alternating bit patterns on both fields.
    send_word('0, '0);
    send_word('1, '0);
    send_word('0, ExpBits'(1));
    send_word('0, '1);
    send_word(ResW'(1), '1);
    send_word(mpe_pkg::PrimeMod - 1, '1);
    send_word(mpe_pkg::PrimeMod - 1, ExpBits'(1));
    send_word(mpe_pkg::PrimeMod, ExpBits'(5));
    send_word(mpe_pkg::PrimeMod + 1, '1);
    send_word('1, '1);
    send_word('1, ExpBits'(3));
    send_word(ResW'(2), ExpBits'(ExpBits - 1));
    send_word(ResW'(2), ExpBits'(1) << (ExpBits - 1));
    send_word(ResW'(30'h2AAAAAAA), ExpBits'(32'h55555555));
    send_word(ResW'(30'h15555555), ExpBits'(32'hAAAAAAAA));
    send_word(ResW'(12345), ExpBits'(mpe_pkg::PrimeMod - 1));   // Fermat: gives 1
    send_word(ResW'(7), ExpBits'(mpe_pkg::PrimeMod - 2));       // modular inverse
    send_word(ResW'(1000000006), ExpBits'(2));

    // Pressure: sender stalls until every expected residue is back.
    wait_block_idle();

    for (int n = 0; n < RandomWords; n++) begin
      if (n % 100 == 0) burst_mode = ($urandom_range(0, 2) == 0);
      if (n == RandomWords / 2) wait_block_idle();
      send_word(pick_base(), pick_exponent());
    end

    wait_block_idle();
    repeat (TailCycles) @(posedge clk_i);
    sb.check_drained();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- mod_prime_exponentiation.f -----
design/mpe_pkg.sv
design/mpe_mulmod.sv
design/mod_prime_exponentiation.sv
bench/tb.sv
